/* hdl/tbdk_pkg.sv */
package tbdk_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned KeyW = 8;
  localparam int unsigned CfgIndexW = 2;

  localparam logic [WordW-1:0] DELTA = 32'h9E3769B9;

  // key register indexes
  localparam logic [CfgIndexW-1:0] KEY_ZERO  = 2'd0;
  localparam logic [CfgIndexW-1:0] KEY_ONE   = 2'd1;
  localparam logic [CfgIndexW-1:0] KEY_TWO   = 2'd2;
  localparam logic [CfgIndexW-1:0] KEY_THREE = 2'd3;

  typedef struct packed {
    logic [WordW-1:0] cipher_left;
    logic [WordW-1:0] cipher_right;
  } blk_t;

  typedef struct packed {
    logic [WordW-1:0] plain_left;
    logic [WordW-1:0] plain_right;
  } res_t;

  // working pair inside the pipeline
  typedef struct packed {
    logic [WordW-1:0] left;
    logic [WordW-1:0] right;
  } pair_t;

  // result push from the last pipeline stage into the output buffer
  typedef struct packed {
    logic  valid;
    pair_t data;
  } push_t;

  // round function of one half round
  function automatic logic [WordW-1:0] feistel_f(
    input logic [WordW-1:0] x,
    input logic [WordW-1:0] sum,
    input logic [KeyW-1:0]  key_shl,
    input logic [KeyW-1:0]  key_shr
  );
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
    a = (x << 4) + {{(WordW-KeyW){1'b0}}, key_shl};
    b = x + sum;
    c = (x >> 5) + {{(WordW-KeyW){1'b0}}, key_shr};
    return a ^ b ^ c;
  endfunction

endpackage

/* hdl/tbdk_out_buffer.sv */
module tbdk_out_buffer (
  input  logic            clk,
  input  logic            rst,
  input  tbdk_pkg::push_t push,
  output logic            full,
  output logic            res_valid,
  input  logic            res_stall,
  output tbdk_pkg::res_t  res_data
);

  logic            skid_valid;
  tbdk_pkg::pair_t skid_data;
  logic            take;

  assign take = res_valid && !res_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        res_data   <= '{plain_left: skid_data.left, plain_right: skid_data.right};
        skid_valid <= 1'b0;
      end
    end else if (push.valid) begin
      if (!res_valid || take) begin
        res_data  <= '{plain_left: push.data.left, plain_right: push.data.right};
        res_valid <= 1'b1;
      end else begin
        // output held, park the item
        skid_data  <= push.data;
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      res_valid <= 1'b0;
    end
  end

endmodule

/* hdl/tea_block_decrypt_byte_key_unit.sv */
// TEA-style 64-bit block decryptor with four byte-wide keys and delta 0x9E3769B9.
// One block enters per cycle on the blk channel while blk_stall is low, and its
// two decrypted words leave on the res channel through the half-round stages and
// the output register. Each half round (three adds, two xors and a subtract) has
// a pipeline stage of its own, so the sustained rate is one item per cycle while
// nothing stalls; the output register and a one-entry skid let the pipe take one
// more item after the result side stalls. Keys are written on the cfg port, index
// 0 to 3, and must only change while no item is in flight; cfg_ready is always high.
module tea_block_decrypt_byte_key_unit #(
  parameter int unsigned ROUND_COUNT = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               blk_valid,
  output logic                               blk_stall,
  input  tbdk_pkg::blk_t                     blk_data,
  output logic                               res_valid,
  input  logic                               res_stall,
  output tbdk_pkg::res_t                     res_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tbdk_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [tbdk_pkg::KeyW-1:0]          cfg_data
);

  localparam int unsigned Stages = 2 * ROUND_COUNT;

  // key registers
  logic [tbdk_pkg::KeyW-1:0] key_zero;
  logic [tbdk_pkg::KeyW-1:0] key_one;
  logic [tbdk_pkg::KeyW-1:0] key_two;
  logic [tbdk_pkg::KeyW-1:0] key_three;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_zero  <= '0;
      key_one   <= '0;
      key_two   <= '0;
      key_three <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tbdk_pkg::KEY_ZERO:  key_zero  <= cfg_data;
        tbdk_pkg::KEY_ONE:   key_one   <= cfg_data;
        tbdk_pkg::KEY_TWO:   key_two   <= cfg_data;
        tbdk_pkg::KEY_THREE: key_three <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipe advances unless the skid holds an item
  logic            buf_full;
  logic            advance;
  logic            stage_valid [Stages];
  tbdk_pkg::pair_t stage_data  [Stages];

  assign advance   = !buf_full;
  assign blk_stall = buf_full;

  genvar k;
  generate
    for (k = 0; k < Stages; k++) begin : g_stage
      // running sum for this round, folded at elaboration
      localparam logic [63:0] SumWide =
        64'(tbdk_pkg::DELTA) * 64'(ROUND_COUNT - k / 2);
      localparam logic [tbdk_pkg::WordW-1:0] Sum = SumWide[tbdk_pkg::WordW-1:0];

      logic            src_valid;
      tbdk_pkg::pair_t src;
      tbdk_pkg::pair_t dst;

      if (k == 0) begin : g_first
        assign src_valid = blk_valid && !blk_stall;
        assign src = '{left: blk_data.cipher_left, right: blk_data.cipher_right};
      end else begin : g_mid
        assign src_valid = stage_valid[k-1];
        assign src       = stage_data[k-1];
      end

      if (k % 2 == 0) begin : g_right
        // first half: second word updated from the first
        assign dst.left  = src.left;
        assign dst.right = src.right -
          tbdk_pkg::feistel_f(src.left, Sum, key_two, key_three);
      end else begin : g_left
        // second half: first word updated from the new second word
        assign dst.right = src.right;
        assign dst.left  = src.left -
          tbdk_pkg::feistel_f(src.right, Sum, key_zero, key_one);
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          stage_valid[k] <= 1'b0;
        end else if (advance) begin
          stage_valid[k] <= src_valid;
        end
      end

      always_ff @(posedge clk) begin
        if (advance) begin
          stage_data[k] <= dst;
        end
      end
    end
  endgenerate

  tbdk_pkg::push_t push;
  assign push.valid = stage_valid[Stages-1] && advance;
  assign push.data  = stage_data[Stages-1];

  tbdk_out_buffer u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (buf_full),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

`ifndef SYNTHESIS
  // a parked item implies the output register is occupied
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    buf_full |-> res_valid)
    else $error("skid holds an item while output is empty");

  // the skid only fills when the result side stalled a valid item
  a_skid_fill_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(buf_full) |-> $past(res_valid && res_stall && stage_valid[Stages-1]))
    else $error("skid filled without an output stall");

  // a frozen pipe keeps its last stage in place
  a_freeze_holds: assert property (@(posedge clk) disable iff (rst)
    buf_full |=> $stable(stage_valid[Stages-1]))
    else $error("pipeline moved while input was stalled");
`endif

endmodule

/* tb/sv/tb_tea_block_decrypt_byte_key_unit.sv */
`timescale 1ns / 100ps

module tb_tea_block_decrypt_byte_key_unit;

  localparam int unsigned ROUNDS = 32;
  localparam logic [tbdk_pkg::WordW-1:0] TEA_DELTA = 32'h9E3769B9;
  // result side holds off this long once, so the pipe fills and stalls its input
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned RAND_PHASES = 9;
  localparam int unsigned PHASE_ITEMS = 181;
  localparam int unsigned DRAIN_CYCLES = 2 * ROUNDS + 16;

  logic clk = 1'b0;
  logic rst;

  logic blk_valid;
  logic blk_stall;
  tbdk_pkg::blk_t blk_data;
  logic res_valid;
  logic res_stall;
  tbdk_pkg::res_t res_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [tbdk_pkg::CfgIndexW-1:0] cfg_index;
  logic [tbdk_pkg::KeyW-1:0] cfg_data;

  // key copy kept in step with every accepted register write
  logic [tbdk_pkg::KeyW-1:0] key_r_shl;   // added to (right << 4) when updating left
  logic [tbdk_pkg::KeyW-1:0] key_r_shr;   // added to (right >> 5) when updating left
  logic [tbdk_pkg::KeyW-1:0] key_l_shl;   // added to (left << 4) when updating right
  logic [tbdk_pkg::KeyW-1:0] key_l_shr;   // added to (left >> 5) when updating right

  tbdk_pkg::res_t plain_expected[$];
  int unsigned blocks_sent = 0;
  int unsigned plains_checked = 0;
  int unsigned mismatch_count = 0;
  int unsigned key_loads = 0;

  // handshake between the processes
  logic tx_idle = 1'b0;
  logic rx_idle = 1'b0;
  logic hold_request = 1'b0;
  logic res_taken = 1'b0;

  // corner blocks, left word in the upper half
  logic [63:0] corner_blocks [0:7] = '{
    64'h00000000_00000000,
    64'hFFFFFFFF_FFFFFFFF,
    64'h00000000_FFFFFFFF,
    64'hFFFFFFFF_00000000,
    64'h80000000_00000001,
    64'h00000001_80000000,
    64'hAAAAAAAA_55555555,
    64'h01234567_89ABCDEF
  };
  // key settings for the corner blocks, key zero in the top byte;
  // the first one is never written, so it runs on the reset keys
  logic [31:0] corner_keys [0:2] = '{
    32'h00000000,
    32'hFFFFFFFF,
    32'h01807FFE
  };

  tea_block_decrypt_byte_key_unit #(
    .ROUND_COUNT(ROUNDS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .blk_valid(blk_valid),
    .blk_stall(blk_stall),
    .blk_data(blk_data),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data(res_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // full decryption of one block with the current keys
  function automatic tbdk_pkg::res_t decrypt_block(input tbdk_pkg::blk_t blk);
    logic [tbdk_pkg::WordW-1:0] left;
    logic [tbdk_pkg::WordW-1:0] right;
    logic [tbdk_pkg::WordW-1:0] sum;
    logic [tbdk_pkg::WordW-1:0] mix;
    tbdk_pkg::res_t plain;
    int r;
    left = blk.cipher_left;
    right = blk.cipher_right;
    sum = TEA_DELTA * 32'(ROUNDS);
    for (r = 0; r < ROUNDS; r++) begin
      // right half first, from the left word
      mix = ((left << 4) + {24'h0, key_l_shl}) ^ (left + sum)
          ^ ((left >> 5) + {24'h0, key_l_shr});
      right = right - mix;
      // then left half, from the updated right word
      mix = ((right << 4) + {24'h0, key_r_shl}) ^ (right + sum)
          ^ ((right >> 5) + {24'h0, key_r_shr});
      left = left - mix;
      sum = sum - TEA_DELTA;
    end
    plain.plain_left = left;
    plain.plain_right = right;
    return plain;
  endfunction

  // mostly random words, with a share of all-zero, all-one and one-hot
  function automatic logic [tbdk_pkg::WordW-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [tbdk_pkg::KeyW-1:0] pick_key_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one register write; only called while nothing is in flight
  task automatic write_key(input logic [tbdk_pkg::CfgIndexW-1:0] idx,
                           input logic [tbdk_pkg::KeyW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      tbdk_pkg::KEY_ZERO:  key_r_shl = val;
      tbdk_pkg::KEY_ONE:   key_r_shr = val;
      tbdk_pkg::KEY_TWO:   key_l_shl = val;
      tbdk_pkg::KEY_THREE: key_l_shr = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_keys(input logic [31:0] keys);
    write_key(tbdk_pkg::KEY_ZERO, keys[31:24]);
    write_key(tbdk_pkg::KEY_ONE, keys[23:16]);
    write_key(tbdk_pkg::KEY_TWO, keys[15:8]);
    write_key(tbdk_pkg::KEY_THREE, keys[7:0]);
    key_loads++;
  endtask

  // offer one block, after a random gap while tx_idle is set, and hold it until taken
  task automatic send_block(input tbdk_pkg::blk_t blk);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      blk_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    blk_valid <= 1'b1;
    blk_data <= blk;
    @(posedge clk);
    while (blk_stall) @(posedge clk);
    plain_expected.push_back(decrypt_block(blk));
    blocks_sent++;
  endtask

  // close a phase: drop valid and wait for every pending result
  task automatic drain_results();
    @(negedge clk);
    blk_valid <= 1'b0;
    while (plain_expected.size() != 0) @(posedge clk);
  endtask

  // result side: a fresh random stall after each taken item while rx_idle is set,
  // plus one long hold-off on request
  initial begin : result_pacer
    int unsigned rx_wait;
    int unsigned hold_left;
    rx_wait = 0;
    hold_left = 0;
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (res_taken) rx_wait = rx_idle ? $urandom_range(0, 4) : 0;
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  // compare each taken result with the oldest pending decryption
  always @(posedge clk) begin : plain_check
    tbdk_pkg::res_t want;
    res_taken = 1'b0;
    if (!rst && res_valid && !res_stall) begin
      res_taken = 1'b1;
      if (plain_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with nothing pending: %h %h", $realtime,
                   res_data.plain_left, res_data.plain_right);
      end else begin
        want = plain_expected.pop_front();
        plains_checked++;
        if (res_data.plain_left !== want.plain_left
            || res_data.plain_right !== want.plain_right) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: plain mismatch: expected %h %h, got %h %h", $realtime,
                     want.plain_left, want.plain_right,
                     res_data.plain_left, res_data.plain_right);
        end
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    tbdk_pkg::blk_t blk;
    int unsigned s;
    int unsigned i;
    int unsigned p;
    rst = 1'b1;
    blk_valid = 1'b0;
    blk_data = '0;
    cfg_valid = 1'b0;
    cfg_index = tbdk_pkg::KEY_ZERO;
    cfg_data = '0;
    key_r_shl = '0;
    key_r_shr = '0;
    key_l_shl = '0;
    key_l_shr = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // corner blocks under reset keys, all-ones keys and a mixed key;
    // no decryption here is readable by eye, so every row goes to the predictor
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    for (s = 0; s < 3; s++) begin
      if (s != 0) load_keys(corner_keys[s]);
      for (i = 0; i < 8; i++) begin
        send_block(tbdk_pkg::blk_t'(corner_blocks[i]));
      end
      drain_results();
    end

    // random phases, each with its own key and pacing mix
    for (p = 0; p < RAND_PHASES; p++) begin
      load_keys({pick_key_byte(), pick_key_byte(), pick_key_byte(), pick_key_byte()});
      tx_idle = (p % 4 == 0) || (p % 4 == 1);
      rx_idle = (p % 4 == 0) || (p % 4 == 2);
      // sender runs flat out while the result side holds off
      if (p == 2) hold_request = 1'b1;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        blk.cipher_left = pick_word();
        blk.cipher_right = pick_word();
        send_block(blk);
      end
      drain_results();
    end

    // catch anything the block sends after the last pending result
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("decrypted %0d blocks under %0d written key settings plus the reset keys",
             blocks_sent, key_loads);
    $display("checked %0d results, %0d failures, one %0d-cycle result hold-off",
             plains_checked, mismatch_count, HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/tbdk_pkg.sv
hdl/tbdk_out_buffer.sv
hdl/tea_block_decrypt_byte_key_unit.sv
tb/sv/tb_tea_block_decrypt_byte_key_unit.sv
